[hdl/lfu_bucket_replacement_assert.svh]
// Assertion macros for the LFU bucket replacement block
`ifndef LFU_BUCKET_REPLACEMENT_ASSERT_SVH
`define LFU_BUCKET_REPLACEMENT_ASSERT_SVH
// a implies b in the next cycle
`define LFU_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
// a implies b in the same cycle
`define LFU_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`endif

[hdl/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Types and constants of the LFU bucket replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;
	localparam int LINE_COUNT_DEF  = 1024;
	localparam int FREQ_LEVELS_DEF = 16;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_ACC   = 3'd1;
	localparam logic [2:0] OP_REM   = 3'd2;
	localparam logic [2:0] OP_DIRTY = 3'd3;
	localparam logic [2:0] OP_CLEAN = 3'd4;
	localparam logic [2:0] OP_EVICT = 3'd5;

	typedef struct packed {
		logic [2:0] operation;
		logic [9:0] line_index;
		logic       dirty_on_add;
	} lfu_in_t;

	typedef struct packed {
		logic [3:0] line_freq;
		logic [9:0] victim_line;
		logic       victim_found;
		logic       op_error;
	} lfu_out_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CLR, ST_SRCH, ST_SRCHW, ST_RDL, ST_RDLW, ST_CHK,
		ST_U_RP, ST_U_RPW, ST_U_WP, ST_U_RN, ST_U_RNW, ST_U_WN, ST_U_RB, ST_U_RBW,
		ST_U_WB, ST_P_RB, ST_P_RBW, ST_P_RH, ST_P_RHW, ST_P_WH, ST_P_WB, ST_DONE
	} lfu_state_t;
endpackage

[hdl/lfu_bucket_replacement.sv]
// ----------------------------------------------------------------------------
// lfu_bucket_replacement
// LFU replacement tracker with per frequency clean/dirty linked buckets.
// ----------------------------------------------------------------------------
// After reset, busy stays high for a clearing pass that sweeps the line memory,
// and the bucket memory is cleared while it runs. Each beat is a read-modify-write
// sequence on one line memory and one bucket memory, each taking one access per
// cycle with a registered read. A beat rejected on its code or line index skips
// the memories. An access, dirty or clean change unlinks the line from its
// bucket, relinking its neighbors, and pushes it at the head of its new bucket.
// Evict first searches the clean buckets from the lowest frequency level up and
// takes the tail line of the first one that is not empty. The result strobe marks
// one beat in the first cycle after busy falls, and a new beat may be accepted in
// that same cycle. The receiver cannot stall results.
`include "lfu_bucket_replacement_assert.svh"
module lfu_bucket_replacement #(
	parameter int LINE_COUNT  = lfu_pkg::LINE_COUNT_DEF,
	parameter int FREQ_LEVELS = lfu_pkg::FREQ_LEVELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lfu_pkg::lfu_in_t  item,
	output logic              done,
	output lfu_pkg::lfu_out_t result
);
	import lfu_pkg::*;

	localparam int LW = $clog2(LINE_COUNT + 1);
	localparam int LA = $clog2(LINE_COUNT);
	localparam int FW = $clog2(FREQ_LEVELS);
	localparam int BA = FW + 1;
	localparam int EW = 2 * LW + FW + 2;
	localparam int BWD = 2 * LW;
	localparam logic [LW-1:0] END = LW'(LINE_COUNT);
	localparam logic [FW-1:0] FTOP = FW'(FREQ_LEVELS - 1);

	// line entry: prev, next, freq, dirty, listed
	typedef struct packed {
		logic [LW-1:0] prev;
		logic [LW-1:0] next;
		logic [FW-1:0] freq;
		logic          dirty;
		logic          listed;
	} ent_t;
	typedef struct packed {
		logic [LW-1:0] head;
		logic [LW-1:0] tail;
	} bkt_t;

	lfu_state_t st_q, st_d;
	logic [LA-1:0] ln_q, clr_q;
	logic [2:0] op_q;
	logic dnew_q, err_q, found_q, unl_q;
	logic [FW-1:0] srch_q;
	ent_t e_q;           // target line entry being modified
	bkt_t b_q;
	logic [BA-1:0] bkt_q;
	ent_t nb_q;          // neighbor entry
	logic [LW-1:0] h_q;

	logic l_we, b_we;
	logic [LA-1:0] l_addr;
	logic [BA-1:0] b_addr;
	ent_t l_wd, l_rd;
	bkt_t b_wd, b_rd;
	logic [EW-1:0] l_rdv;
	logic [BWD-1:0] b_rdv;
	logic [BA:0] bclr_q;
	logic bclr_done;

	// bucket memory clear rides along with the line clear (buckets < lines)
	logic [BA-1:0] bclr_addr;

	assign l_rd = ent_t'(l_rdv);
	assign b_rd = bkt_t'(b_rdv);
	assign bclr_done = bclr_q[BA];
	assign bclr_addr = bclr_q[BA-1:0];

	lfu_ram #(.WIDTH(EW), .DEPTH(LINE_COUNT)) u_line (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(EW'(l_wd)), .rdata(l_rdv));
	lfu_ram #(.WIDTH(BWD), .DEPTH(2 * FREQ_LEVELS)) u_bkt (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(BWD'(b_wd)), .rdata(b_rdv));

	function automatic logic [BA-1:0] bkt_of(input ent_t e);
		return {e.freq, e.dirty};
	endfunction

	assign busy = (st_q != ST_IDLE);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLR:   if (clr_q == LA'(LINE_COUNT - 1) && bclr_done) st_d = ST_IDLE;
			ST_IDLE:  if (start) begin
				if (item.operation == OP_EVICT) st_d = ST_SRCH;
				else if (item.operation > OP_EVICT ||
					32'(item.line_index) >= LINE_COUNT) st_d = ST_DONE;
				else st_d = ST_RDL;
			end
			ST_SRCH:  st_d = ST_SRCHW;
			ST_SRCHW: begin
				if (b_rd.tail != END) st_d = ST_RDL;
				else if (srch_q == FTOP) st_d = ST_DONE;
				else st_d = ST_SRCH;
			end
			ST_RDL:   st_d = ST_RDLW;
			ST_RDLW:  st_d = ST_CHK;
			ST_CHK:   st_d = err_q ? ST_DONE : (unl_q ? ST_U_RP : ST_P_RB);
			ST_U_RP:  st_d = (e_q.prev != END) ? ST_U_RPW : ST_U_RN;
			ST_U_RPW: st_d = ST_U_WP;
			ST_U_WP:  st_d = ST_U_RN;
			ST_U_RN:  st_d = (e_q.next != END) ? ST_U_RNW : ST_U_RB;
			ST_U_RNW: st_d = ST_U_WN;
			ST_U_WN:  st_d = ST_U_RB;
			ST_U_RB:  st_d = ST_U_RBW;
			ST_U_RBW: st_d = ST_U_WB;
			ST_U_WB:  st_d = (op_q == OP_REM) ? ST_DONE : ST_P_RB;
			ST_P_RB:  st_d = ST_P_RBW;
			ST_P_RBW: st_d = ST_P_RH;
			ST_P_RH:  st_d = (b_q.head != END) ? ST_P_RHW : ST_P_WB;
			ST_P_RHW: st_d = ST_P_WH;
			ST_P_WH:  st_d = ST_P_WB;
			ST_P_WB:  st_d = ST_DONE;
			ST_DONE:  st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		l_we = 1'b0; b_we = 1'b0;
		l_addr = ln_q; b_addr = bkt_q;
		l_wd = e_q; b_wd = b_q;
		unique case (st_q)
			ST_CLR: begin
				l_we = 1'b1; l_addr = clr_q;
				l_wd = '{prev: END, next: END, freq: '0, dirty: 1'b0, listed: 1'b0};
				b_we = !bclr_done; b_addr = bclr_addr;
				b_wd = '{head: END, tail: END};
			end
			ST_SRCH: b_addr = {srch_q, 1'b0};
			ST_U_RP: l_addr = e_q.prev[LA-1:0];
			ST_U_WP: begin
				l_we = 1'b1; l_addr = e_q.prev[LA-1:0];
				l_wd = nb_q; l_wd.next = e_q.next;
			end
			ST_U_RN: l_addr = e_q.next[LA-1:0];
			ST_U_WN: begin
				l_we = 1'b1; l_addr = e_q.next[LA-1:0];
				l_wd = nb_q; l_wd.prev = e_q.prev;
			end
			ST_U_WB: begin
				b_we = 1'b1;
				if (e_q.prev == END) b_wd.head = e_q.next;
				if (e_q.next == END) b_wd.tail = e_q.prev;
				if (op_q == OP_REM) begin
					l_we = 1'b1;
					l_wd.prev = END; l_wd.next = END; l_wd.listed = 1'b0;
				end
			end
			ST_P_RB: b_addr = bkt_of(e_q);
			ST_P_RH: l_addr = b_q.head[LA-1:0];
			ST_P_WH: begin
				l_we = 1'b1; l_addr = h_q[LA-1:0];
				l_wd = nb_q; l_wd.prev = {1'b0, ln_q};
			end
			ST_P_WB: begin
				b_we = 1'b1; b_wd.head = {1'b0, ln_q};
				if (b_q.tail == END) b_wd.tail = {1'b0, ln_q};
				l_we = 1'b1; l_wd.prev = END; l_wd.next = b_q.head; l_wd.listed = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			bclr_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLR) clr_q <= clr_q + 1'b1;
			if (!bclr_done) bclr_q <= bclr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				op_q <= item.operation;
				ln_q <= item.line_index[LA-1:0];
				dnew_q <= item.dirty_on_add;
				err_q <= (item.operation > OP_EVICT) || (item.operation != OP_EVICT &&
					32'(item.line_index) >= LINE_COUNT);
				found_q <= 1'b0; srch_q <= '0;
			end
			ST_SRCHW: if (b_rd.tail != END) begin
				ln_q <= b_rd.tail[LA-1:0]; found_q <= 1'b1;
			end else srch_q <= srch_q + 1'b1;
			ST_RDLW: begin
				e_q <= l_rd;
				unl_q <= (op_q != OP_ADD);
				if (op_q == OP_ADD) err_q <= l_rd.listed;
				else if (op_q != OP_EVICT && !l_rd.listed) err_q <= 1'b1;
				else if (op_q == OP_DIRTY) err_q <= l_rd.dirty;
				else if (op_q == OP_CLEAN) err_q <= !l_rd.dirty;
				bkt_q <= bkt_of(l_rd);
			end
			ST_CHK: if (op_q == OP_ADD) begin
				e_q.freq <= '0; e_q.dirty <= dnew_q;
				bkt_q <= {{FW{1'b0}}, dnew_q};
			end
			ST_U_RPW, ST_U_RNW, ST_P_RHW: nb_q <= l_rd;
			ST_U_RBW: b_q <= b_rd;
			ST_U_WB: begin
				if (op_q == OP_ACC && e_q.freq != FTOP) e_q.freq <= e_q.freq + 1'b1;
				if (op_q == OP_EVICT) e_q.freq <= '0;
				if (op_q == OP_DIRTY) e_q.dirty <= 1'b1;
				if (op_q == OP_CLEAN) e_q.dirty <= 1'b0;
			end
			ST_P_RB: bkt_q <= bkt_of(e_q);
			ST_P_RBW: begin b_q <= b_rd; h_q <= b_rd.head; end
			default: ;
		endcase
	end

	// result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			result <= '0;
		end else begin
			done <= (st_q == ST_DONE);
			result.op_error <= err_q;
			result.victim_found <= found_q;
			result.victim_line <= found_q ? 10'(ln_q) : '0;
			result.line_freq <= (err_q || (op_q == OP_EVICT)) ? '0 : 4'(e_q.freq);
		end
	end

	`LFU_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`LFU_ASSERT_NOW(a_busy_done, clk, arst_n, st_q == ST_DONE, busy)
	`LFU_ASSERT_NOW(a_found_evict, clk, arst_n, done && result.victim_found, !result.op_error)
endmodule

[hdl/lfu_ram.sv]
// ----------------------------------------------------------------------------
// lfu_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
